// ----- rtl/note_to_fm_fnum_block_macros.svh -----
// Assertion macros shared by the pitch converter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef NOTE_TO_FM_FNUM_BLOCK_MACROS_SVH
`define NOTE_TO_FM_FNUM_BLOCK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NFFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NFFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nffb_pkg.sv -----
// Types, constants and the base frequency table of the pitch converter.
// Depends on nothing; used by the interfaces and the top level.
package nffb_pkg;

    localparam int TONE_W  = 19;
    localparam int FRAC_W  = 12;
    localparam int NOTE_W  = 7;
    localparam int FNUM_W  = 10;
    localparam int BLK_W   = 3;
    localparam int MOFF_W  = 2;
    localparam int BASE_W  = 13;
    localparam int SHF_W   = 17;
    localparam int FREQ_W  = 18;
    localparam int BEND_W  = 10;
    localparam int PROD_W  = SHF_W + BEND_W;
    localparam int OCT_W   = 4;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 4;

    localparam logic [FRAC_W-1:0] FRAC_HALF   = 12'd2048;
    localparam logic [FRAC_W:0]   FRAC_ONE    = 13'd4096;
    localparam logic [NOTE_W-1:0] OCT_NOTES   = 7'd12;
    localparam logic [5:0]        NOTE_RECIP  = 6'd43;
    localparam int                RECIP_SHIFT = 9;
    localparam logic [4:0]        BEND_UP     = 5'd31;
    localparam logic [4:0]        BEND_DOWN   = 5'd27;
    localparam logic [OCT_W-1:0]  OCT_REF     = 4'd5;
    localparam logic [FREQ_W-1:0] FNUM_MAX    = 18'h003FF;
    localparam logic [CNT_W-1:0]  BLK_TOP     = 4'd7;
    localparam logic [CNT_W-1:0]  BLK_FIRST   = 4'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_MUL,
        S_BEND,
        S_NORM,
        S_DONE
    } t_state;

    function automatic logic [BASE_W-1:0] base_freq(input logic [IDX_W-1:0] idx);
        logic [BASE_W-1:0] f;
        unique case (idx)
            4'd0:    f = 13'h0AB7;
            4'd1:    f = 13'h0B5A;
            4'd2:    f = 13'h0C07;
            4'd3:    f = 13'h0CBE;
            4'd4:    f = 13'h0D80;
            4'd5:    f = 13'h0E4D;
            4'd6:    f = 13'h0F27;
            4'd7:    f = 13'h100E;
            4'd8:    f = 13'h1102;
            4'd9:    f = 13'h1205;
            4'd10:   f = 13'h1318;
            4'd11:   f = 13'h143A;
            default: f = 13'h0AB7;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/nffb_if.sv -----
// Valid/ready channel interfaces of the pitch converter: pitch in, fnum out.
// Depends on nffb_pkg.
interface nffb_tone_if
    import nffb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TONE_W-1:0] tone;

    modport source (output valid, output tone, input ready);
    modport sink   (input valid, input tone, output ready);
endinterface

interface nffb_fnum_if
    import nffb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FNUM_W-1:0] fnum;
    logic [BLK_W-1:0]  block;
    logic [MOFF_W-1:0] mult_boost;

    modport source (output valid, output fnum, output block, output mult_boost, input ready);
    modport sink   (input valid, input fnum, input block, input mult_boost, output ready);
endinterface

// ----- rtl/note_to_fm_fnum_block.sv -----
// Pitch (7.12 semitones) to FM fnum, octave block and multiplier offset.
// Depends on nffb_pkg, nffb_if.sv and note_to_fm_fnum_block_macros.svh.
//
//  channel    dir  payload                        handshake
//  i_tone_ch  in   tone[18:0]                     valid/ready
//  o_res_ch   out  fnum[9:0] block[2:0] boost[1:0] valid/ready
//
// After accept an item passes four fixed steps (octave split, table and
// bend factor, multiply, bend), then the normalize loop, which halves the
// value until a compare finds it in range, then the output load.
// The input is ready only while the sequencer is idle.
// A result waits in the output register; the sequencer stalls in its last
// step only while that register is still full and not being taken.
// Synchronous active-low reset clears the sequencer and the output valid.
`include "note_to_fm_fnum_block_macros.svh"

module note_to_fm_fnum_block
    import nffb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    nffb_tone_if.sink    i_tone_ch,
    nffb_fnum_if.source  o_res_ch
);

    t_state               r_state, n_state;
    logic [NOTE_W-1:0]    r_note, n_note;
    logic                 r_neg, n_neg;
    logic [FRAC_W-1:0]    r_mag, n_mag;
    logic [OCT_W-1:0]     r_oct, n_oct;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [FREQ_W-1:0]    r_freq, n_freq;
    logic [BEND_W-1:0]    r_d, n_d;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [CNT_W-1:0]     r_blk, n_blk;

    logic                 r_out_valid, n_out_valid;
    logic [FNUM_W-1:0]    r_out_fnum, n_out_fnum;
    logic [BLK_W-1:0]     r_out_blk, n_out_blk;
    logic [MOFF_W-1:0]    r_out_moff, n_out_moff;

    logic                 in_acc;
    logic                 out_free;
    logic [NOTE_W-1:0]    in_whole;
    logic [FRAC_W-1:0]    in_frac;
    logic [NOTE_W-1:0]    in_note;
    logic [NOTE_W+5:0]    recip_prod;
    logic [OCT_W-1:0]     quot;
    logic [NOTE_W:0]      quot_x12;
    logic [BASE_W-1:0]    base;
    logic [SHF_W-1:0]     shifted;
    logic [4:0]           bend_k;
    logic [FRAC_W+6:0]    bend_prod;
    logic [FRAC_W-1:0]    delta;
    logic [SHF_W-1:0]     bent;

    always_comb begin
        in_acc     = i_tone_ch.valid && (r_state == S_IDLE);
        out_free   = !r_out_valid || o_res_ch.ready;
        in_whole   = i_tone_ch.tone[TONE_W-1:FRAC_W];
        in_frac    = i_tone_ch.tone[FRAC_W-1:0];
        in_note    = (in_whole >= OCT_NOTES) ? (in_whole - OCT_NOTES) : in_whole;

        recip_prod = {6'd0, r_note} * {7'd0, NOTE_RECIP};
        quot       = recip_prod[RECIP_SHIFT +: OCT_W];
        quot_x12   = {4'd0, quot} * {1'b0, OCT_NOTES};

        base       = base_freq(r_idx);
        if (r_oct < OCT_REF) begin
            shifted = {4'd0, base} >> (OCT_REF - r_oct);
        end else begin
            shifted = {4'd0, base} << (r_oct - OCT_REF);
        end
        bend_k     = r_neg ? BEND_DOWN : BEND_UP;
        bend_prod  = {5'd0, r_mag, 2'b00} * {14'd0, bend_k};

        delta      = r_prod[PROD_W-1 -: FRAC_W];
        bent       = r_neg ? (r_freq[SHF_W-1:0] - {5'd0, delta})
                           : (r_freq[SHF_W-1:0] + {5'd0, delta});
    end

    always_comb begin
        n_state     = r_state;
        n_note      = r_note;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_oct       = r_oct;
        n_idx       = r_idx;
        n_freq      = r_freq;
        n_d         = r_d;
        n_prod      = r_prod;
        n_blk       = r_blk;
        n_out_valid = r_out_valid && !o_res_ch.ready;
        n_out_fnum  = r_out_fnum;
        n_out_blk   = r_out_blk;
        n_out_moff  = r_out_moff;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_frac > FRAC_HALF) begin
                        n_note = in_note + 7'd1;
                        n_neg  = 1'b1;
                        n_mag  = FRAC_W'(FRAC_ONE - {1'b0, in_frac});
                    end else begin
                        n_note = in_note;
                        n_neg  = 1'b0;
                        n_mag  = in_frac;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_oct   = quot;
                n_idx   = IDX_W'(r_note - quot_x12[NOTE_W-1:0]);
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_freq  = {1'b0, shifted};
                n_d     = bend_prod[17:8];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = r_d * r_freq[SHF_W-1:0];
                n_state = S_BEND;
            end
            S_BEND: begin
                n_freq  = {bent, 1'b0};
                n_blk   = BLK_FIRST;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (r_freq > FNUM_MAX) begin
                    n_freq = r_freq >> 1;
                    n_blk  = r_blk + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fnum  = r_freq[FNUM_W-1:0];
                    if (r_blk > BLK_TOP) begin
                        n_out_blk  = BLK_TOP[BLK_W-1:0];
                        n_out_moff = MOFF_W'(r_blk - BLK_TOP);
                    end else begin
                        n_out_blk  = r_blk[BLK_W-1:0];
                        n_out_moff = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note     <= n_note;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_oct      <= n_oct;
        r_idx      <= n_idx;
        r_freq     <= n_freq;
        r_d        <= n_d;
        r_prod     <= n_prod;
        r_blk      <= n_blk;
        r_out_fnum <= n_out_fnum;
        r_out_blk  <= n_out_blk;
        r_out_moff <= n_out_moff;
    end

    assign i_tone_ch.ready     = (r_state == S_IDLE);
    assign o_res_ch.valid      = r_out_valid;
    assign o_res_ch.fnum       = r_out_fnum;
    assign o_res_ch.block      = r_out_blk;
    assign o_res_ch.mult_boost = r_out_moff;

    `NFFB_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_PREP, "accept did not start sequencer")
    `NFFB_ASSERT_NOW(a_done_normalized, i_clk, i_rst_n, r_state == S_DONE, r_freq <= FNUM_MAX, "fnum not normalized")
    `NFFB_ASSERT_NOW(a_blk_range, i_clk, i_rst_n, r_state == S_DONE, (r_blk >= BLK_FIRST) && (r_blk <= 4'd9), "block count out of range")
    `NFFB_ASSERT_NOW(a_out_offset, i_clk, i_rst_n, o_res_ch.valid, (o_res_ch.block != 3'd0) && ((o_res_ch.mult_boost == 2'd0) || (o_res_ch.block == 3'd7)), "multiplier offset without top block")

endmodule

// ----- tb/note_to_fm_fnum_block_checker.sv -----
// Result checker for the pitch to FM fnum converter: watches both channels,
// predicts fnum, block and multiplier offset per pitch item and compares.
// Depends on nffb_pkg and the channel interfaces in nffb_if.sv.
`timescale 1ns / 1ps

module note_to_fm_fnum_block_checker
    import nffb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    nffb_tone_if  i_tone_ch,
    nffb_fnum_if  i_res_ch,
    output int    o_err_cnt,
    output int    o_pending,
    output int    o_checked
);

    typedef struct packed {
        logic [FNUM_W-1:0] fnum;
        logic [BLK_W-1:0]  block;
        logic [MOFF_W-1:0] mult_boost;
    } t_fm_setting;

    localparam int unsigned SEMITONE_FREQ [12] = '{
        'hAB7, 'hB5A, 'hC07, 'hCBE, 'hD80, 'hE4D,
        'hF27, 'h100E, 'h1102, 'h1205, 'h1318, 'h143A
    };

    t_fm_setting expected_settings [$];
    int          err_cnt = 0;
    int          checked_cnt = 0;

    assign o_err_cnt = err_cnt;
    assign o_checked = checked_cnt;

    function automatic t_fm_setting predict_fm_setting(input logic [TONE_W-1:0] tone);
        int unsigned note;
        int unsigned frac;
        int unsigned octave;
        int unsigned freq;
        int unsigned depth;
        int unsigned blk;
        int          bend;
        t_fm_setting s;
        note = tone[TONE_W-1:FRAC_W];
        frac = tone[FRAC_W-1:0];
        if (note >= OCT_NOTES)
            note = note - OCT_NOTES;
        bend = frac;
        if (frac > FRAC_HALF) begin
            note = note + 1;
            bend = bend - int'(FRAC_ONE);
        end
        octave = note / OCT_NOTES;
        freq   = SEMITONE_FREQ[note % OCT_NOTES];
        if (octave < OCT_REF)
            freq = freq >> (OCT_REF - octave);
        else
            freq = freq << (octave - OCT_REF);
        bend = bend * 4;
        if (bend > 0) begin
            depth = (int'(bend) * BEND_UP) >> 8;
            freq  = freq + ((depth * freq) >> 15);
        end else if (bend < 0) begin
            depth = (int'(-bend) * BEND_DOWN) >> 8;
            freq  = freq - ((depth * freq) >> 15);
        end
        freq = freq * 2;
        blk  = BLK_FIRST;
        while (freq > FNUM_MAX) begin
            freq = freq >> 1;
            blk  = blk + 1;
        end
        s.fnum = freq[FNUM_W-1:0];
        if (blk > BLK_TOP) begin
            s.mult_boost = MOFF_W'(blk - BLK_TOP);
            s.block      = BLK_W'(BLK_TOP);
        end else begin
            s.mult_boost = '0;
            s.block      = BLK_W'(blk);
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_fm_setting want;
        if (i_rst_n) begin
            if (i_tone_ch.valid && i_tone_ch.ready)
                expected_settings.push_back(predict_fm_setting(i_tone_ch.tone));
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (expected_settings.size() == 0) begin
                    report_mismatch("unexpected result, fnum", i_res_ch.fnum, -1);
                end else begin
                    want = expected_settings.pop_front();
                    checked_cnt++;
                    if (i_res_ch.fnum !== want.fnum)
                        report_mismatch("fnum", i_res_ch.fnum, want.fnum);
                    if (i_res_ch.block !== want.block)
                        report_mismatch("block", i_res_ch.block, want.block);
                    if (i_res_ch.mult_boost !== want.mult_boost)
                        report_mismatch("mult_boost", i_res_ch.mult_boost, want.mult_boost);
                end
            end
        end
        o_pending <= expected_settings.size();
    end

endmodule

// ----- tb/note_to_fm_fnum_block_tb.sv -----
// Top of the pitch converter testbench: clock, reset, pitch stimulus and
// output back-pressure; checking is done by note_to_fm_fnum_block_checker.
// Depends on nffb_pkg, nffb_if.sv, the block and the checker.
`timescale 1ns / 1ps

module note_to_fm_fnum_block_tb
    import nffb_pkg::*;
;

    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_TAIL    = 100;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 20;

    localparam logic [TONE_W-1:0] DIRECTED_TONES [N_DIRECTED] = '{
        {7'd0,   12'd0},    {7'd127, 12'd4095}, {7'd11,  12'd2048}, {7'd11,  12'd2049},
        {7'd11,  12'd0},    {7'd12,  12'd0},    {7'd23,  12'd4095}, {7'd127, 12'd2048},
        {7'd127, 12'd0},    {7'd126, 12'd1},    {7'd60,  12'd1},    {7'd60,  12'd4095},
        {7'd69,  12'd2047}, {7'd0,   12'd2049}, {7'd5,   12'hAAA},  {7'd100, 12'h555},
        {7'd24,  12'd2048}, {7'd71,  12'd3000}, {7'd1,   12'd4095}, {7'd119, 12'd2049}
    };

    logic i_clk;
    logic i_rst_n;
    bit   calm = 1'b0;
    int   sent_cnt = 0;
    int   cycle_cnt = 0;
    int   err_cnt;
    int   pending_cnt;
    int   checked_cnt;

    nffb_tone_if tone_ch ();
    nffb_fnum_if res_ch ();

    note_to_fm_fnum_block DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tone_ch (tone_ch),
        .o_res_ch  (res_ch)
    );

    note_to_fm_fnum_block_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tone_ch (tone_ch),
        .i_res_ch  (res_ch),
        .o_err_cnt (err_cnt),
        .o_pending (pending_cnt),
        .o_checked (checked_cnt)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_tone(input logic [TONE_W-1:0] tone);
        tone_ch.valid <= 1'b1;
        tone_ch.tone  <= tone;
        do @(posedge i_clk); while (!tone_ch.ready);
        sent_cnt++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            tone_ch.valid <= 1'b0;
            tone_ch.tone  <= TONE_W'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    function automatic logic [TONE_W-1:0] random_tone();
        logic [NOTE_W-1:0] whole;
        logic [FRAC_W-1:0] frac;
        whole = NOTE_W'($urandom_range(0, 127));
        frac  = FRAC_W'($urandom);
        case ($urandom_range(0, 5))
            0: frac = '0;
            1: frac = FRAC_HALF;
            2: frac = FRAC_HALF + FRAC_W'($urandom_range(0, 2)) - 1'b1;
            3: frac = '1;
            default: ;
        endcase
        return {whole, frac};
    endfunction

    initial begin
        int taken;
        bit held;
        res_ch.ready <= 1'b0;
        taken = 0;
        held  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                taken++;
            if (taken == HOLD_AT && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end
        end
    end

    initial begin
        tone_ch.valid <= 1'b0;
        tone_ch.tone  <= '0;
        i_rst_n       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_TONES[k])
            send_tone(DIRECTED_TONES[k]);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k >= RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            send_tone(random_tone());
        end
        tone_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pitch items (%0d directed, rest random over all notes and fractions),",
                 sent_cnt, N_DIRECTED);
        $display("checked %0d results, with a %0d-cycle output hold-off backing up the input.",
                 checked_cnt, HOLD_CYCLES);
        if (err_cnt == 0 && pending_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- note_to_fm_fnum_block.f -----
+incdir+rtl
rtl/nffb_pkg.sv
rtl/nffb_if.sv
rtl/note_to_fm_fnum_block.sv
tb/note_to_fm_fnum_block_checker.sv
tb/note_to_fm_fnum_block_tb.sv
